// ----- sv/spi_dfps_pkg.sv -----
// ----------------------------------------------------------------------------
// SPI dataflash page sequencer package
// Shared types, codes and constants of the page sequencer.
// ----------------------------------------------------------------------------
package spi_dfps_pkg;

  localparam int unsigned PageCount  = 2048;
  localparam int unsigned PageSize   = 264;

  localparam logic [7:0] OpStatus   = 8'hD7;
  localparam logic [7:0] OpWrite    = 8'h82;
  localparam logic [7:0] OpRead     = 8'hE8;
  localparam logic [7:0] ReadyBit   = 8'h80;
  localparam logic [8:0] OffsetHigh = 9'h100;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CmdRead  = 2'd0,
    CmdWrite = 2'd1,
    CmdWdata = 2'd2,
    CmdRxByte = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KindSend   = 3'd0,
    KindDesel  = 3'd1,
    KindData   = 3'd2,
    KindDone   = 3'd3,
    KindReject = 3'd4
  } kind_e;

  typedef enum logic [6:0] {
    PhIdle     = 7'b0000001,
    PhPollCmd  = 7'b0000010,
    PhPollStat = 7'b0000100,
    PhHeader   = 7'b0001000,
    PhRdata    = 7'b0010000,
    PhWwait    = 7'b0100000,
    PhWdata    = 7'b1000000
  } phase_e;

  typedef struct packed {
    cmd_e        command;
    logic [10:0] page;
    logic [8:0]  offset;
    logic [15:0] length;
    logic [7:0]  byte_value;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]                cnt;
    res_t [MaxResults-1:0]     res;
  } push_t;

  function automatic logic [7:0] header_byte(input logic        is_write,
                                             input logic [10:0] page,
                                             input logic [8:0]  offset,
                                             input logic [2:0]  idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = is_write ? OpWrite : OpRead;
      3'd1:    b = {4'd0, page[10:7]};
      3'd2:    b = {page[6:0], |(offset & OffsetHigh)};
      3'd3:    b = offset[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/spi_dfps_core.sv -----
// ----------------------------------------------------------------------------
// SPI dataflash page sequencer core
// Holds the sequence state and turns one input beat into up to three results.
// ----------------------------------------------------------------------------
module spi_dfps_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  spi_dfps_pkg::in_t  in_data_i,
  output spi_dfps_pkg::push_t push_o
);

  spi_dfps_pkg::phase_e phase_q, phase_d;
  logic        is_write_q, is_write_d;
  logic [10:0] page_q, page_d;
  logic [8:0]  offset_q, offset_d;
  logic [15:0] left_q, left_d;
  logic [2:0]  hcount_q, hcount_d;

  spi_dfps_pkg::res_t [spi_dfps_pkg::MaxResults-1:0] res;
  logic [1:0] n;
  logic [2:0] hnext;
  logic [15:0] left_dec;
  logic        range_bad;

  assign hnext     = hcount_q + 3'd1;
  assign left_dec  = left_q - 16'd1;
  assign range_bad = (32'(in_data_i.page) >= spi_dfps_pkg::PageCount) ||
                     (32'(in_data_i.offset) >= spi_dfps_pkg::PageSize);

  always_comb begin
    phase_d    = phase_q;
    is_write_d = is_write_q;
    page_d     = page_q;
    offset_d   = offset_q;
    left_d     = left_q;
    hcount_d   = hcount_q;
    res        = '0;
    n          = 2'd0;
    if (accept_i) begin
      unique case (in_data_i.command) inside
        spi_dfps_pkg::CmdRead, spi_dfps_pkg::CmdWrite: begin
          if (phase_q != spi_dfps_pkg::PhIdle || range_bad) begin
            res[n] = '{spi_dfps_pkg::KindReject, 8'd0, 1'b0};
            n = n + 2'd1;
          end else begin
            is_write_d = (in_data_i.command == spi_dfps_pkg::CmdWrite);
            page_d     = in_data_i.page;
            offset_d   = in_data_i.offset;
            left_d     = in_data_i.length;
            hcount_d   = 3'd0;
            if (in_data_i.command == spi_dfps_pkg::CmdRead) begin
              phase_d = spi_dfps_pkg::PhPollCmd;
              res[n] = '{spi_dfps_pkg::KindSend, spi_dfps_pkg::OpStatus, 1'b0};
              n = n + 2'd1;
            end else begin
              phase_d = spi_dfps_pkg::PhHeader;
              res[n] = '{spi_dfps_pkg::KindSend, spi_dfps_pkg::OpWrite, 1'b0};
              n = n + 2'd1;
            end
          end
        end
        spi_dfps_pkg::CmdWdata: begin
          if (phase_q == spi_dfps_pkg::PhWwait) begin
            phase_d = spi_dfps_pkg::PhWdata;
            res[n] = '{spi_dfps_pkg::KindSend, in_data_i.byte_value, 1'b0};
            n = n + 2'd1;
          end
        end
        default: begin
          unique case (phase_q)
            spi_dfps_pkg::PhPollCmd: begin
              phase_d = spi_dfps_pkg::PhPollStat;
              res[n] = '{spi_dfps_pkg::KindSend, 8'd0, 1'b0};
              n = n + 2'd1;
            end
            spi_dfps_pkg::PhPollStat: begin
              res[n] = '{spi_dfps_pkg::KindDesel, 8'd0, 1'b0};
              n = n + 2'd1;
              if ((in_data_i.byte_value & spi_dfps_pkg::ReadyBit) == 8'd0) begin
                phase_d = spi_dfps_pkg::PhPollCmd;
                res[n] = '{spi_dfps_pkg::KindSend, spi_dfps_pkg::OpStatus, 1'b0};
                n = n + 2'd1;
              end else if (is_write_q) begin
                phase_d = spi_dfps_pkg::PhIdle;
                res[n] = '{spi_dfps_pkg::KindDone, 8'd0, 1'b0};
                n = n + 2'd1;
              end else begin
                phase_d  = spi_dfps_pkg::PhHeader;
                hcount_d = 3'd0;
                res[n] = '{spi_dfps_pkg::KindSend, spi_dfps_pkg::OpRead, 1'b0};
                n = n + 2'd1;
              end
            end
            spi_dfps_pkg::PhHeader: begin
              hcount_d = hnext;
              if (hnext != 3'd0 && (!is_write_q || hnext < 3'd4)) begin
                res[n] = '{spi_dfps_pkg::KindSend,
                           spi_dfps_pkg::header_byte(is_write_q, page_q, offset_q, hnext),
                           1'b0};
                n = n + 2'd1;
              end else if (left_q != 16'd0) begin
                if (is_write_q) begin
                  phase_d = spi_dfps_pkg::PhWwait;
                end else begin
                  phase_d = spi_dfps_pkg::PhRdata;
                  res[n] = '{spi_dfps_pkg::KindSend, 8'd0, 1'b0};
                  n = n + 2'd1;
                end
              end else if (is_write_q) begin
                phase_d = spi_dfps_pkg::PhPollCmd;
                res[n] = '{spi_dfps_pkg::KindDesel, 8'd0, 1'b0};
                n = n + 2'd1;
                res[n] = '{spi_dfps_pkg::KindSend, spi_dfps_pkg::OpStatus, 1'b0};
                n = n + 2'd1;
              end else begin
                phase_d = spi_dfps_pkg::PhIdle;
                res[n] = '{spi_dfps_pkg::KindDesel, 8'd0, 1'b0};
                n = n + 2'd1;
                res[n] = '{spi_dfps_pkg::KindDone, 8'd0, 1'b0};
                n = n + 2'd1;
              end
            end
            spi_dfps_pkg::PhRdata: begin
              left_d = left_dec;
              res[n] = '{spi_dfps_pkg::KindData, in_data_i.byte_value, 1'b0};
              n = n + 2'd1;
              if (left_dec != 16'd0) begin
                res[n] = '{spi_dfps_pkg::KindSend, 8'd0, 1'b0};
                n = n + 2'd1;
              end else begin
                phase_d = spi_dfps_pkg::PhIdle;
                res[n] = '{spi_dfps_pkg::KindDesel, 8'd0, 1'b0};
                n = n + 2'd1;
                res[n] = '{spi_dfps_pkg::KindDone, 8'd0, 1'b0};
                n = n + 2'd1;
              end
            end
            spi_dfps_pkg::PhWdata: begin
              left_d = left_dec;
              if (left_dec != 16'd0) begin
                phase_d = spi_dfps_pkg::PhWwait;
              end else begin
                phase_d = spi_dfps_pkg::PhPollCmd;
                res[n] = '{spi_dfps_pkg::KindDesel, 8'd0, 1'b0};
                n = n + 2'd1;
                res[n] = '{spi_dfps_pkg::KindSend, spi_dfps_pkg::OpStatus, 1'b0};
                n = n + 2'd1;
              end
            end
            default: begin
            end
          endcase
        end
      endcase
      if (n != 2'd0) begin
        res[n - 2'd1].last = 1'b1;
      end
    end
  end

  assign push_o.cnt = n;
  assign push_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= spi_dfps_pkg::PhIdle;
      is_write_q <= 1'b0;
      page_q     <= '0;
      offset_q   <= '0;
      left_q     <= '0;
      hcount_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      is_write_q <= is_write_d;
      page_q     <= page_d;
      offset_q   <= offset_d;
      left_q     <= left_d;
      hcount_q   <= hcount_d;
    end
  end

endmodule

// ----- sv/spi_dfps_queue.sv -----
// ----------------------------------------------------------------------------
// SPI dataflash page sequencer result queue
// Takes up to three results in a cycle and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module spi_dfps_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spi_dfps_pkg::push_t  push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spi_dfps_pkg::res_t   out_data_o
);

  spi_dfps_pkg::res_t [spi_dfps_pkg::QueueDepth-1:0] mem_q;
  logic [spi_dfps_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [spi_dfps_pkg::QueueCntW-1:0] count_q, count_d;
  logic pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign room_o      = (32'(count_q) + spi_dfps_pkg::MaxResults <= spi_dfps_pkg::QueueDepth);

  assign wr_ptr_d = wr_ptr_q + spi_dfps_pkg::QueuePtrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + spi_dfps_pkg::QueuePtrW'(pop);
  assign count_d  = count_q + spi_dfps_pkg::QueueCntW'(push_i.cnt)
                  - spi_dfps_pkg::QueueCntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < spi_dfps_pkg::MaxResults; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[wr_ptr_q + spi_dfps_pkg::QueuePtrW'(i)] <= push_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- sv/spi_dataflash_page_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// SPI dataflash page sequencer
// Turns page read and write requests into SPI bytes, driven by received bytes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Beat
//  in       input      in_valid_i/in_ready_o   request, write byte or rx byte
//  out      output     out_valid_o/out_ready_i send, deselect, data, done, reject
//
// An input beat updates the state in the cycle it is accepted and queues its
// zero to three results, which leave one per cycle while out_ready_i is high.
// The input is ready whenever the four-entry result queue has room for three.
// Reset returns the sequencer to idle and empties the queue.
// ----------------------------------------------------------------------------
module spi_dataflash_page_sequencer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spi_dfps_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spi_dfps_pkg::res_t out_data_o
);

  spi_dfps_pkg::push_t push;
  logic room;

  assign in_ready_o = room;

  spi_dfps_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_valid_i & room),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  spi_dfps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/tb_spi_dataflash_page_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the SPI dataflash page sequencer
// A short table of directed beats is followed by reactive random traffic that
// mostly walks well-formed read and write sequences, with stray beats mixed in.
// Every accepted input beat runs through a predictor of the sequencer, and
// each output beat is compared field by field with the oldest prediction.
// Both sides idle at random, the receiver once holds off long enough for the
// input to stall, and the sender waits for all results to drain mid-run and at the end.
// ----------------------------------------------------------------------------
module tb_spi_dataflash_page_sequencer_unit;

  localparam int unsigned Beats       = 360;
  localparam int unsigned GapMax      = 18;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 1500;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 50;

  typedef struct {
    spi_dfps_pkg::in_t  beat;
    bit                 typed;
    spi_dfps_pkg::res_t want;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  spi_dfps_pkg::in_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  spi_dfps_pkg::res_t out_data_o;

  spi_dfps_pkg::phase_e sq_phase;
  logic                 sq_is_write;
  logic [10:0]          sq_page;
  logic [8:0]           sq_offset;
  logic [15:0]          sq_left;
  logic [2:0]           sq_hdr;

  spi_dfps_pkg::res_t pending_spi[$];
  spi_dfps_pkg::res_t step_out[$];
  row_t               plan[$];

  int errors;
  int idle_cycles;
  bit send_burst;
  bit recv_burst;
  bit hold_out;
  bit offering;

  spi_dataflash_page_sequencer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MaxReports) begin
      $display("mismatch: %s got %0h expected %0h", what, got, want);
    end
  endtask

  function automatic void queue_result(spi_dfps_pkg::kind_e k, logic [7:0] v);
    spi_dfps_pkg::res_t r;
    if (step_out.size() < spi_dfps_pkg::MaxResults) begin
      r.kind     = k;
      r.out_byte = v;
      r.last     = 1'b0;
      step_out.push_back(r);
    end
  endfunction

  function automatic logic [7:0] header_out(logic [2:0] idx);
    case (idx)
      3'd0:    return sq_is_write ? spi_dfps_pkg::OpWrite : spi_dfps_pkg::OpRead;
      3'd1:    return {4'd0, sq_page[10:7]};
      3'd2:    return {sq_page[6:0], sq_offset[8]};
      3'd3:    return sq_offset[7:0];
      default: return 8'h00;
    endcase
  endfunction

  function automatic void begin_poll();
    sq_phase = spi_dfps_pkg::PhPollCmd;
    queue_result(spi_dfps_pkg::KindSend, spi_dfps_pkg::OpStatus);
  endfunction

  function automatic void begin_header();
    sq_phase = spi_dfps_pkg::PhHeader;
    sq_hdr   = 3'd0;
    queue_result(spi_dfps_pkg::KindSend, header_out(3'd0));
  endfunction

  function automatic void step_sequencer(spi_dfps_pkg::in_t b);
    int                 hdr_len;
    spi_dfps_pkg::res_t r;
    step_out.delete();
    case (b.command)
      spi_dfps_pkg::CmdRead, spi_dfps_pkg::CmdWrite: begin
        if (sq_phase != spi_dfps_pkg::PhIdle || b.page >= spi_dfps_pkg::PageCount ||
            b.offset >= spi_dfps_pkg::PageSize) begin
          queue_result(spi_dfps_pkg::KindReject, 8'h00);
        end else begin
          sq_is_write = (b.command == spi_dfps_pkg::CmdWrite);
          sq_page     = b.page;
          sq_offset   = b.offset;
          sq_left     = b.length;
          sq_hdr      = 3'd0;
          if (sq_is_write) begin_header();
          else begin_poll();
        end
      end
      spi_dfps_pkg::CmdWdata: begin
        if (sq_phase == spi_dfps_pkg::PhWwait) begin
          sq_phase = spi_dfps_pkg::PhWdata;
          queue_result(spi_dfps_pkg::KindSend, b.byte_value);
        end
      end
      default: begin
        case (sq_phase)
          spi_dfps_pkg::PhPollCmd: begin
            sq_phase = spi_dfps_pkg::PhPollStat;
            queue_result(spi_dfps_pkg::KindSend, 8'h00);
          end
          spi_dfps_pkg::PhPollStat: begin
            queue_result(spi_dfps_pkg::KindDesel, 8'h00);
            if ((b.byte_value & spi_dfps_pkg::ReadyBit) == 8'h00) begin
              begin_poll();
            end else if (sq_is_write) begin
              sq_phase = spi_dfps_pkg::PhIdle;
              queue_result(spi_dfps_pkg::KindDone, 8'h00);
            end else begin
              begin_header();
            end
          end
          spi_dfps_pkg::PhHeader: begin
            hdr_len = sq_is_write ? 4 : 8;
            sq_hdr  = sq_hdr + 3'd1;
            if (sq_hdr != 3'd0 && int'(sq_hdr) < hdr_len) begin
              queue_result(spi_dfps_pkg::KindSend, header_out(sq_hdr));
            end else if (sq_left != 16'd0) begin
              if (sq_is_write) begin
                sq_phase = spi_dfps_pkg::PhWwait;
              end else begin
                sq_phase = spi_dfps_pkg::PhRdata;
                queue_result(spi_dfps_pkg::KindSend, 8'h00);
              end
            end else if (sq_is_write) begin
              queue_result(spi_dfps_pkg::KindDesel, 8'h00);
              begin_poll();
            end else begin
              sq_phase = spi_dfps_pkg::PhIdle;
              queue_result(spi_dfps_pkg::KindDesel, 8'h00);
              queue_result(spi_dfps_pkg::KindDone, 8'h00);
            end
          end
          spi_dfps_pkg::PhRdata: begin
            queue_result(spi_dfps_pkg::KindData, b.byte_value);
            sq_left = sq_left - 16'd1;
            if (sq_left != 16'd0) begin
              queue_result(spi_dfps_pkg::KindSend, 8'h00);
            end else begin
              sq_phase = spi_dfps_pkg::PhIdle;
              queue_result(spi_dfps_pkg::KindDesel, 8'h00);
              queue_result(spi_dfps_pkg::KindDone, 8'h00);
            end
          end
          spi_dfps_pkg::PhWdata: begin
            sq_left = sq_left - 16'd1;
            if (sq_left != 16'd0) begin
              sq_phase = spi_dfps_pkg::PhWwait;
            end else begin
              queue_result(spi_dfps_pkg::KindDesel, 8'h00);
              begin_poll();
            end
          end
          default: ;
        endcase
      end
    endcase
    if (step_out.size() != 0) begin
      r      = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  function automatic row_t row(spi_dfps_pkg::cmd_e c, int pg, int off, int len, int bv,
                               bit typed, spi_dfps_pkg::kind_e k, int ob);
    row_t t;
    t.beat.command    = c;
    t.beat.page       = 11'(pg);
    t.beat.offset     = 9'(off);
    t.beat.length     = 16'(len);
    t.beat.byte_value = 8'(bv);
    t.typed           = typed;
    t.want.kind       = k;
    t.want.out_byte   = 8'(ob);
    t.want.last       = 1'b1;
    return t;
  endfunction

  task automatic put_beat(spi_dfps_pkg::in_t b, bit typed, spi_dfps_pkg::res_t want);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, GapMax);
    if (gap > 0) begin
      if (offering) in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    offering   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    step_sequencer(b);
    if (typed) begin
      pending_spi.push_back(want);
    end else begin
      foreach (step_out[i]) pending_spi.push_back(step_out[i]);
    end
  endtask

  task automatic drain_results();
    if (offering) in_valid_i <= 1'b0;
    offering = 1'b0;
    do @(posedge clk_i); while (pending_spi.size() != 0);
  endtask

  always @(posedge clk_i) begin : watch
    spi_dfps_pkg::res_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid_o && out_ready_i) begin
        if (pending_spi.size() == 0) begin
          report_mismatch("result beat with nothing expected, kind", int'(out_data_o.kind), 0);
        end else begin
          want = pending_spi.pop_front();
          if (out_data_o.kind !== want.kind)
            report_mismatch("kind", int'(out_data_o.kind), int'(want.kind));
          if (out_data_o.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(out_data_o.out_byte), int'(want.out_byte));
          if (out_data_o.last !== want.last)
            report_mismatch("last", int'(out_data_o.last), int'(want.last));
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("FAIL spi_dataflash_page_sequencer_unit");
        $finish;
      end
    end
  end

  initial begin : receiver
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
      end else begin
        if ($urandom_range(0, 24) == 0) recv_burst = ($urandom_range(0, 2) == 0);
        stall = recv_burst ? 0 : $urandom_range(0, GapMax);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : sender
    spi_dfps_pkg::in_t  b;
    spi_dfps_pkg::res_t none;
    int                 n_sent;
    int                 r;
    bit                 stray;
    bit                 held;
    bit                 paused;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    none        = '0;
    sq_phase    = spi_dfps_pkg::PhIdle;
    sq_is_write = 1'b0;
    sq_page     = '0;
    sq_offset   = '0;
    sq_left     = '0;
    sq_hdr      = '0;
    n_sent      = 0;
    held        = 1'b0;
    paused      = 1'b0;

    plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'h00, 0,
                       spi_dfps_pkg::KindSend, 0));
    plan.push_back(row(spi_dfps_pkg::CmdWdata, 2047, 511, 16'hFFFF, 8'hFF, 0,
                       spi_dfps_pkg::KindSend, 0));
    plan.push_back(row(spi_dfps_pkg::CmdRead, 0, 264, 16'hFFFF, 8'h00, 1,
                       spi_dfps_pkg::KindReject, 0));
    plan.push_back(row(spi_dfps_pkg::CmdWrite, 2047, 511, 16'hFFFF, 8'hFF, 1,
                       spi_dfps_pkg::KindReject, 0));
    plan.push_back(row(spi_dfps_pkg::CmdRead, 2047, 263, 1, 8'h00, 1,
                       spi_dfps_pkg::KindSend, spi_dfps_pkg::OpStatus));
    plan.push_back(row(spi_dfps_pkg::CmdWrite, 0, 0, 0, 8'h00, 1,
                       spi_dfps_pkg::KindReject, 0));
    plan.push_back(row(spi_dfps_pkg::CmdWdata, 0, 0, 0, 8'h5A, 0,
                       spi_dfps_pkg::KindSend, 0));
    plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'hFF, 0,
                       spi_dfps_pkg::KindSend, 0));
    plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'h7F, 0,
                       spi_dfps_pkg::KindSend, 0));
    plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'h00, 0,
                       spi_dfps_pkg::KindSend, 0));
    plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'h80, 0,
                       spi_dfps_pkg::KindSend, 0));
    for (int i = 0; i < 8; i++) begin
      plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'h11 * i, 0,
                         spi_dfps_pkg::KindSend, 0));
    end
    plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'hA5, 0,
                       spi_dfps_pkg::KindSend, 0));
    plan.push_back(row(spi_dfps_pkg::CmdWrite, 0, 0, 0, 8'h00, 1,
                       spi_dfps_pkg::KindSend, spi_dfps_pkg::OpWrite));
    for (int i = 0; i < 4; i++) begin
      plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'h3C, 0,
                         spi_dfps_pkg::KindSend, 0));
    end
    plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'h00, 0,
                       spi_dfps_pkg::KindSend, 0));
    plan.push_back(row(spi_dfps_pkg::CmdRxByte, 0, 0, 0, 8'hFF, 0,
                       spi_dfps_pkg::KindSend, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) put_beat(plan[i].beat, plan[i].typed, plan[i].want);

    while (n_sent < Beats || sq_phase != spi_dfps_pkg::PhIdle) begin
      if ($urandom_range(0, 29) == 0) send_burst = ($urandom_range(0, 2) == 0);
      b.command    = spi_dfps_pkg::cmd_e'($urandom_range(0, 3));
      b.page       = 11'($urandom);
      b.offset     = 9'($urandom);
      b.length     = 16'($urandom);
      b.byte_value = 8'($urandom);
      stray = ($urandom_range(0, 11) == 0);
      if (!stray) begin
        if (sq_phase == spi_dfps_pkg::PhIdle) begin
          b.command = ($urandom_range(0, 1) == 1) ? spi_dfps_pkg::CmdWrite
                                                  : spi_dfps_pkg::CmdRead;
          b.offset  = 9'($urandom_range(0, spi_dfps_pkg::PageSize - 1));
          r = $urandom_range(0, 19);
          if (r < 14) b.length = 16'($urandom_range(0, 4));
          else if (r < 19) b.length = 16'($urandom_range(5, 24));
          else b.length = 16'($urandom_range(25, 80));
        end else if (sq_phase == spi_dfps_pkg::PhWwait) begin
          b.command = spi_dfps_pkg::CmdWdata;
        end else begin
          b.command = spi_dfps_pkg::CmdRxByte;
          if (sq_phase == spi_dfps_pkg::PhPollStat) begin
            b.byte_value[7] = ($urandom_range(0, 2) != 0);
          end
        end
      end
      put_beat(b, 1'b0, none);
      if (!stray) n_sent++;
      if (n_sent >= 150 && !held) begin
        held     = 1'b1;
        hold_out = 1'b1;
      end
      if (n_sent >= 300 && !paused) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS spi_dataflash_page_sequencer_unit");
    end else begin
      $display("FAIL spi_dataflash_page_sequencer_unit");
    end
    $finish;
  end

endmodule
